FILE: rtl/substring_occurrence_counter_core_assert.svh
// assertion macros for the substring counter rtl
`ifndef SUBSTRING_OCCURRENCE_COUNTER_CORE_ASSERT_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SOC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define SOC_ASSERT_ONEHOT0(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) \
        else $error(msg);
`else
`define SOC_ASSERT(label, clk, rst_n, prop, msg)
`define SOC_ASSERT_ONEHOT0(label, clk, rst_n, sig, msg)
`endif
`endif

FILE: rtl/soc_pkg.sv
package soc_pkg;

    localparam int PAT_MAX   = 256;
    localparam int LEN_W     = $clog2(PAT_MAX + 1);
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } soc_kind_t;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } soc_state_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              clear_flags;
        logic              clear_pattern;
        logic              shift_text;
        logic              append;
        logic [BYTE_W-1:0] data;
    } soc_cell_ctrl_t;

endpackage

FILE: rtl/soc_if.sv
interface soc_item_if;
    logic                         valid;
    logic                         ready;
    logic [soc_pkg::KIND_W-1:0]   kind;
    logic [soc_pkg::BYTE_W-1:0]   byte_value;
    logic                         text_last;

    modport source (output valid, output kind, output byte_value, output text_last,
                    input ready);
    modport sink (input valid, input kind, input byte_value, input text_last,
                  output ready);
endinterface

interface soc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         match_here;
    logic [soc_pkg::COUNT_W-1:0]  match_count;
    logic                         text_done;

    modport source (output valid, output match_here, output match_count,
                    output text_done, input ready);
    modport sink (input valid, input match_here, input match_count,
                  input text_done, output ready);
endinterface

FILE: rtl/soc_cell.sv
module soc_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  soc_pkg::soc_cell_ctrl_t ctrl,
    input  logic                    prev_flag,
    input  logic                    prev_tail,
    output logic                    flag,
    output logic                    tail,
    output logic                    hit
);

    logic                       flag_reg;
    logic                       flag_next;
    logic                       tail_reg;
    logic                       tail_next;
    logic [soc_pkg::BYTE_W-1:0] pat_reg;

    // prefix through this cell matched, ending at the newest text byte
    always_comb
    begin
        flag_next = flag_reg;
        if (ctrl.clear_flags)
        begin
            flag_next = 1'b0;
        end
        else if (ctrl.shift_text)
        begin
            flag_next = prev_flag && (ctrl.data == pat_reg);
        end
    end

    // tail marks the last pattern byte; prev_tail marks the next free cell
    always_comb
    begin
        tail_next = tail_reg;
        if (ctrl.clear_pattern)
        begin
            tail_next = 1'b0;
        end
        else if (ctrl.append)
        begin
            tail_next = prev_tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.append && prev_tail)
        begin
            pat_reg <= ctrl.data;
        end
    end

    assign flag = flag_reg;
    assign tail = tail_reg;
    assign hit  = flag_reg && tail_reg;

endmodule

FILE: rtl/soc_cell_row.sv
module soc_cell_row (
    input  logic                          clk,
    input  logic                          rst_n,
    input  soc_pkg::soc_cell_ctrl_t       ctrl,
    input  logic                          pattern_empty,
    output logic [soc_pkg::PAT_MAX-1:0]   hit_vec
);

    logic [soc_pkg::PAT_MAX:0] flag_chain;
    logic [soc_pkg::PAT_MAX:0] tail_chain;

    // empty prefix always matches; an empty pattern writes into the first cell
    assign flag_chain[0] = 1'b1;
    assign tail_chain[0] = pattern_empty;

    for (genvar j = 0; j < soc_pkg::PAT_MAX; j++)
    begin : g_cell
        soc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_flag (flag_chain[j]),
            .prev_tail (tail_chain[j]),
            .flag      (flag_chain[j+1]),
            .tail      (tail_chain[j+1]),
            .hit       (hit_vec[j])
        );
    end

endmodule

FILE: rtl/substring_occurrence_counter_core.sv
// channel  dir  fields                              beat
// item     in   kind, byte_value, text_last         valid && ready
// result   out  match_here, match_count, text_done  valid && ready
//
// per item the cell row updates at the accepting edge; the hit is reduced and the
// result registered in the evaluate state once the output register is free
// one item in flight; a new item is taken while the previous result waits
// a stalled result holds the evaluate cycle until the output register frees
// reset clears control, flags and the pattern length; no clearing pass
`include "substring_occurrence_counter_core_assert.svh"

module substring_occurrence_counter_core (
    input logic          clk,
    input logic          rst_n,
    soc_item_if.sink     item,
    soc_result_if.source result
);

    soc_pkg::soc_state_t             state_reg;
    soc_pkg::soc_state_t             state_next;
    soc_pkg::soc_kind_t              kind_reg;
    soc_pkg::soc_kind_t              item_kind;
    logic                            last_reg;
    logic [soc_pkg::LEN_W-1:0]       pat_len_reg;
    logic [soc_pkg::LEN_W-1:0]       pat_len_next;
    logic [soc_pkg::COUNT_W-1:0]     count_reg;
    logic [soc_pkg::COUNT_W-1:0]     count_next;
    logic [soc_pkg::COUNT_W-1:0]     count_calc;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_here_reg;
    logic [soc_pkg::COUNT_W-1:0]     out_count_reg;
    logic                            out_done_reg;
    logic                            accept;
    logic                            out_free;
    logic                            load_out;
    logic                            here;
    logic                            done;
    logic                            clear_kind;
    logic [soc_pkg::PAT_MAX-1:0]     hit_vec;
    soc_pkg::soc_cell_ctrl_t         ctrl;

    assign item_kind = soc_pkg::soc_kind_t'(item.kind);
    assign accept    = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;

    assign clear_kind = (kind_reg == soc_pkg::KIND_APPEND) ||
                        (kind_reg == soc_pkg::KIND_CLEAR);
    assign here = (kind_reg == soc_pkg::KIND_TEXT) && (|hit_vec);
    assign done = (kind_reg == soc_pkg::KIND_TEXT) && last_reg;

    always_comb
    begin
        if (clear_kind)
        begin
            count_calc = '0;
        end
        else if (here && (count_reg != soc_pkg::COUNT_MAX))
        begin
            count_calc = count_reg + soc_pkg::COUNT_W'(1);
        end
        else
        begin
            count_calc = count_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item.ready  = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            soc_pkg::S_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    state_next = soc_pkg::S_EVAL;
                end
            end
            soc_pkg::S_EVAL:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = soc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = soc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.data          = item.byte_value;
        ctrl.shift_text    = accept && (item_kind == soc_pkg::KIND_TEXT);
        ctrl.clear_pattern = accept && (item_kind == soc_pkg::KIND_CLEAR);
        ctrl.append        = accept && (item_kind == soc_pkg::KIND_APPEND) &&
                             (pat_len_reg != soc_pkg::LEN_W'(soc_pkg::PAT_MAX));
        // the window empties on pattern edits and after the closing text beat
        ctrl.clear_flags   = (accept && ((item_kind == soc_pkg::KIND_APPEND) ||
                                         (item_kind == soc_pkg::KIND_CLEAR))) ||
                             (load_out && done);
    end

    always_comb
    begin
        pat_len_next = pat_len_reg;
        if (ctrl.clear_pattern)
        begin
            pat_len_next = '0;
        end
        else if (ctrl.append)
        begin
            pat_len_next = pat_len_reg + soc_pkg::LEN_W'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (load_out)
        begin
            count_next = done ? '0 : count_calc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= soc_pkg::S_IDLE;
            pat_len_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pat_len_reg   <= pat_len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= item_kind;
            last_reg <= item.text_last;
        end
        if (load_out)
        begin
            out_here_reg  <= here;
            out_count_reg <= count_calc;
            out_done_reg  <= done;
        end
    end

    soc_cell_row u_row (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .pattern_empty (pat_len_reg == '0),
        .hit_vec       (hit_vec)
    );

    assign result.valid       = out_valid_reg;
    assign result.match_here  = out_here_reg;
    assign result.match_count = out_count_reg;
    assign result.text_done   = out_done_reg;

    `SOC_ASSERT(a_accept_to_eval, clk, rst_n, accept |=> state_reg == soc_pkg::S_EVAL, "item beat did not start evaluation")
    `SOC_ASSERT_ONEHOT0(a_single_tail_hit, clk, rst_n, hit_vec, "more than one pattern tail hit")
    `SOC_ASSERT(a_empty_no_hit, clk, rst_n, (pat_len_reg == '0) |-> (hit_vec == '0), "hit with empty pattern")
    `SOC_ASSERT(a_done_clears_count, clk, rst_n, (load_out && done) |=> (count_reg == '0), "count kept after text end")

endmodule

FILE: dv/occurrence_checker.sv
module occurrence_checker (
    input  logic   clk,
    input  logic   rst_n,
    soc_item_if    item,
    soc_result_if  result,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        logic                        match_here;
        logic [soc_pkg::COUNT_W-1:0] match_count;
        logic                        text_done;
    } count_beat_t;

    logic [soc_pkg::BYTE_W-1:0]  pat_bytes [soc_pkg::PAT_MAX];
    logic [soc_pkg::LEN_W-1:0]   pat_len;
    logic [soc_pkg::BYTE_W-1:0]  text_win [soc_pkg::PAT_MAX];
    logic [soc_pkg::LEN_W-1:0]   win_fill;
    logic [soc_pkg::COUNT_W-1:0] occ_count;
    count_beat_t                 expected_counts [$];
    int                          mismatches;

    function automatic void clear_text();
        for (int i = 0; i < soc_pkg::PAT_MAX; i++)
            text_win[i] = '0;
        win_fill  = '0;
        occ_count = '0;
    endfunction

    function automatic count_beat_t count_step(soc_pkg::soc_kind_t kind,
                                               logic [soc_pkg::BYTE_W-1:0] data,
                                               logic last);
        count_beat_t r;
        logic        hit;
        r = '0;
        case (kind)
            soc_pkg::KIND_APPEND:
            begin
                // a full pattern ignores the byte but still drops the text
                if (pat_len < soc_pkg::PAT_MAX)
                begin
                    pat_bytes[pat_len[$clog2(soc_pkg::PAT_MAX)-1:0]] = data;
                    pat_len = pat_len + 1'b1;
                end
                clear_text();
            end
            soc_pkg::KIND_CLEAR:
            begin
                pat_len = '0;
                clear_text();
            end
            soc_pkg::KIND_TEXT:
            begin
                for (int i = soc_pkg::PAT_MAX - 1; i > 0; i--)
                    text_win[i] = text_win[i-1];
                text_win[0] = data;
                if (win_fill < soc_pkg::PAT_MAX)
                    win_fill = win_fill + 1'b1;
                hit = (pat_len != 0) && (win_fill >= pat_len);
                // newest window byte lines up with the last pattern byte
                for (int i = 0; i < pat_len; i++)
                    if (text_win[i] != pat_bytes[pat_len-1-i])
                        hit = 1'b0;
                if (hit)
                begin
                    r.match_here = 1'b1;
                    if (occ_count != soc_pkg::COUNT_MAX)
                        occ_count = occ_count + 1'b1;
                end
                r.text_done = last;
            end
            default: ;
        endcase
        r.match_count = occ_count;
        if (kind == soc_pkg::KIND_TEXT && last)
            clear_text();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        count_beat_t got;
        count_beat_t want;
        if (!rst_n)
        begin
            pat_len = '0;
            clear_text();
            expected_counts.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{result.match_here, result.match_count, result.text_done};
                if (expected_counts.size() == 0)
                begin
                    $error("result beat with nothing pending: match_count %0d",
                           got.match_count);
                    mismatches++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (got.match_here !== want.match_here)
                    begin
                        $error("match_here: expected %0d, got %0d",
                               want.match_here, got.match_here);
                        mismatches++;
                    end
                    if (got.match_count !== want.match_count)
                    begin
                        $error("match_count: expected %0d, got %0d",
                               want.match_count, got.match_count);
                        mismatches++;
                    end
                    if (got.text_done !== want.text_done)
                    begin
                        $error("text_done: expected %0d, got %0d",
                               want.text_done, got.text_done);
                        mismatches++;
                    end
                end
            end
            if (item.valid && item.ready)
                expected_counts.push_back(count_step(soc_pkg::soc_kind_t'(item.kind),
                                                     item.byte_value, item.text_last));
            fail_count <= mismatches;
            pending    <= expected_counts.size();
        end
    end

endmodule

FILE: dv/tb.sv
module tb;

    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;
    int   items_sent = 0;

    soc_item_if   item_ch ();
    soc_result_if result_ch ();

    substring_occurrence_counter_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    occurrence_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[substring_occurrence_counter_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic set_idling(int send_pct, int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    task automatic send_item(soc_pkg::soc_kind_t kind, logic [soc_pkg::BYTE_W-1:0] data,
                             logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= kind;
        item_ch.byte_value <= data;
        item_ch.text_last  <= last;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    // longest pattern plus appends past the limit, then the text carries it twice so the window runs full
    task automatic full_pattern_text();
        logic [soc_pkg::BYTE_W-1:0] pat [soc_pkg::PAT_MAX];
        send_item(soc_pkg::KIND_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < soc_pkg::PAT_MAX; i++)
        begin
            pat[i] = soc_pkg::BYTE_W'($urandom);
            send_item(soc_pkg::KIND_APPEND, pat[i], 1'b0);
        end
        for (int i = 0; i < 3; i++)
            send_item(soc_pkg::KIND_APPEND, soc_pkg::BYTE_W'($urandom), 1'b0);
        for (int i = 0; i < 5; i++)
            send_item(soc_pkg::KIND_TEXT, soc_pkg::BYTE_W'($urandom), 1'b0);
        for (int i = 0; i < 2 * soc_pkg::PAT_MAX; i++)
            send_item(soc_pkg::KIND_TEXT, pat[i % soc_pkg::PAT_MAX],
                      i == 2 * soc_pkg::PAT_MAX - 1);
    endtask

    // short patterns over a two-symbol alphabet so hits are frequent
    task automatic random_texts(int quota);
        logic [soc_pkg::BYTE_W-1:0] sym [2];
        logic [soc_pkg::BYTE_W-1:0] pat [12];
        logic [soc_pkg::BYTE_W-1:0] data;
        int                         start;
        int                         plen;
        int                         tlen;
        int                         n;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(99) < 80)
            begin
                sym[0] = soc_pkg::BYTE_W'($urandom);
                sym[1] = soc_pkg::BYTE_W'($urandom);
                plen = ($urandom_range(9) == 0) ? int'($urandom_range(5, 12)) :
                                                  int'($urandom_range(1, 4));
                send_item(soc_pkg::KIND_CLEAR, soc_pkg::BYTE_W'($urandom), 1'($urandom));
                for (int i = 0; i < plen; i++)
                begin
                    pat[i] = sym[1'($urandom_range(1))];
                    send_item(soc_pkg::KIND_APPEND, pat[i], 1'($urandom));
                end
                tlen = int'($urandom_range(1, 40));
                n = 0;
                while (n < tlen)
                begin
                    if ($urandom_range(9) < 3 && n + plen <= tlen)
                    begin
                        for (int i = 0; i < plen; i++)
                            send_item(soc_pkg::KIND_TEXT, pat[i], n + i == tlen - 1);
                        n += plen;
                    end
                    else
                    begin
                        if ($urandom_range(19) == 0)
                            send_item(soc_pkg::KIND_NOP, soc_pkg::BYTE_W'($urandom),
                                      1'($urandom));
                        data = ($urandom_range(19) == 0) ? soc_pkg::BYTE_W'($urandom) :
                                                           sym[1'($urandom_range(1))];
                        send_item(soc_pkg::KIND_TEXT, data, n == tlen - 1);
                        n++;
                    end
                end
            end
            else
                send_item(soc_pkg::soc_kind_t'($urandom_range(3)),
                          soc_pkg::BYTE_W'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= soc_pkg::KIND_NOP;
        item_ch.byte_value <= '0;
        item_ch.text_last  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern, then unused kind
        send_item(soc_pkg::KIND_TEXT, 8'h41, 1'b1);
        send_item(soc_pkg::KIND_NOP, 8'hFF, 1'b1);
        // hit on the last byte of the text
        send_item(soc_pkg::KIND_APPEND, 8'h00, 1'b0);
        send_item(soc_pkg::KIND_APPEND, 8'hFF, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'h00, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hFF, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'h00, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hFF, 1'b1);
        // overlapping hits, count reported mid-text
        send_item(soc_pkg::KIND_CLEAR, 8'h80, 1'b1);
        send_item(soc_pkg::KIND_APPEND, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_APPEND, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_NOP, 8'h00, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b1);
        send_item(soc_pkg::KIND_TEXT, 8'h55, 1'b1);
        // append in the middle of a text drops the window
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_APPEND, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b1);
        send_item(soc_pkg::KIND_CLEAR, 8'h7F, 1'b0);
        send_item(soc_pkg::KIND_TEXT, 8'hAA, 1'b1);

        full_pattern_text();

        set_idling(0, 0);
        random_texts(170);
        set_idling(58, 0);
        random_texts(170);
        set_idling(0, 58);
        random_texts(170);
        set_idling(37, 37);
        random_texts(170);

        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[substring_occurrence_counter_core] OK");
        else
            $display("[substring_occurrence_counter_core] ERROR");
        $finish;
    end

endmodule
